// File: hw/rtl/sle_pkg.sv
package sle_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int IO_DATA_W = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 7;

    localparam logic [INDEX_W-1:0] NONE_INDEX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT      = 3'd0,
        CMD_APPEND      = 3'd1,
        CMD_DELETE_LAST = 3'd2,
        CMD_SEARCH      = 3'd3,
        CMD_CLEAR       = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_ERROR    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SEARCH = 2'd2
    } t_cell_op;

endpackage

// File: hw/rtl/sle_cell.sv
module sle_cell
    import sle_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int SLOT_W     = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic [SLOT_W-1:0]     i_fill,
    input  logic [SLOT_W-1:0]     i_tail_sel,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_prev,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match,
    output logic [DATA_WIDTH-1:0] o_tail
);

    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_match;

    // An insert writes the key at its slot and moves every live entry at or above it up by one.
    // A search result is held until the next search so that a stalled output still sees it.
    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_INSERT: begin
                if (IDX == i_slot) begin
                    r_data <= i_key;
                end else if ((IDX > i_slot) && (IDX <= i_fill)) begin
                    r_data <= i_prev;
                end
            end
            CELL_SEARCH: begin
                r_match <= (IDX < i_fill) && (r_data == i_key);
            end
            default: begin
            end
        endcase
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_tail  = (IDX == i_tail_sel) ? r_data : '0;

endmodule

// File: hw/rtl/sle_first_match.sv
module sle_first_match
    import sle_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6
) (
    input  logic [CAPACITY-1:0] i_match,
    output logic                o_any,
    output logic [IDX_W-1:0]    o_index
);

    logic [CAPACITY-1:0] lowest;

    // Isolating the lowest set bit leaves a one-hot vector that encodes directly.
    assign lowest = i_match & (~i_match + CAPACITY'(1));
    assign o_any  = |i_match;

    always_comb begin
        o_index = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_index = o_index | (lowest[i] ? IDX_W'(i) : '0);
        end
    end

endmodule

// File: hw/rtl/sequential_list_engine.sv
// A transferred command is held in the busy state; its result is registered once the output
// register is free, and no new command is taken until then.
// Every command costs the same, since each entry cell shifts or compares in parallel.
// Reset empties the list and clears the handshake state; entry contents are undefined
// until written and are never read before that.
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [POS_W-1:0]     i_position,
    input  logic [IO_DATA_W-1:0] i_data_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [INDEX_W-1:0]   o_found_index,
    output logic [IO_DATA_W-1:0] o_data_out,
    output logic [COUNT_W-1:0]   o_count,
    output logic                 o_empty_res
);

    localparam int FW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = ((FW > POS_W) ? FW : POS_W) + 1;
    localparam logic [FW-1:0] FULL = FW'(CAPACITY);

    logic                  r_busy;
    logic [FW-1:0]         r_fill;
    t_status               r_status;
    logic                  r_is_search;
    logic                  r_is_delete;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [INDEX_W-1:0]    r_out_found;
    logic [IO_DATA_W-1:0]  r_out_data;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_empty;

    logic                  in_fire;
    logic                  resolve;
    t_cmd                  cmd;
    logic [DATA_WIDTH-1:0] key;
    logic [CW-1:0]         pos_ext;
    logic [CW-1:0]         fill_ext;
    logic                  bad_pos;
    logic                  full;
    t_status               n_status;
    logic [FW-1:0]         n_fill;
    t_cell_op              cell_op;
    logic [FW-1:0]         slot;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] chain [CAPACITY];
    logic [DATA_WIDTH-1:0] tail  [CAPACITY];
    logic [CAPACITY-1:0]   match;
    logic [DATA_WIDTH-1:0] tail_value;
    logic                  any_match;
    logic [IDX_W-1:0]      first_index;

    assign o_in_ready = !r_busy;
    assign in_fire    = i_in_valid && !r_busy;
    assign resolve    = r_busy && (!r_out_valid || i_out_ready);

    assign cmd      = t_cmd'(i_cmd);
    assign key      = DATA_WIDTH'(i_data_in);
    assign pos_ext  = CW'(i_position);
    assign fill_ext = CW'(r_fill);
    assign bad_pos  = (pos_ext == '0) || (pos_ext > fill_ext + CW'(1));
    assign full     = (r_fill >= FULL);

    always_comb begin
        n_status = ST_OK;
        n_fill   = r_fill;
        cell_op  = CELL_HOLD;
        slot     = r_fill;
        case (cmd)
            CMD_INSERT: begin
                if (bad_pos) begin
                    n_status = ST_ERROR;
                end else if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    cell_op = CELL_INSERT;
                    slot    = FW'(pos_ext - CW'(1));
                    n_fill  = r_fill + FW'(1);
                end
            end
            CMD_APPEND: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    cell_op = CELL_INSERT;
                    n_fill  = r_fill + FW'(1);
                end
            end
            CMD_DELETE_LAST: begin
                if (r_fill == '0) begin
                    n_status = ST_ERROR;
                end else begin
                    n_fill = r_fill - FW'(1);
                end
            end
            CMD_SEARCH: begin
                cell_op = CELL_SEARCH;
            end
            CMD_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_status = ST_ERROR;
            end
        endcase
        if (!in_fire) begin
            cell_op = CELL_HOLD;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign chain[g] = '0;
        end else begin : g_link
            assign chain[g] = cell_data[g-1];
        end

        sle_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .SLOT_W     (FW),
            .INDEX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (cell_op),
            .i_slot     (slot),
            .i_fill     (r_fill),
            .i_tail_sel (r_fill),
            .i_key      (key),
            .i_prev     (chain[g]),
            .o_data     (cell_data[g]),
            .o_match    (match[g]),
            .o_tail     (tail[g])
        );
    end

    always_comb begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            tail_value = tail_value | tail[i];
        end
    end

    sle_first_match #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_first_match (
        .i_match  (match),
        .o_any    (any_match),
        .o_index  (first_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_busy      <= 1'b1;
                r_fill      <= n_fill;
                r_status    <= n_status;
                r_is_search <= (cmd == CMD_SEARCH);
                r_is_delete <= (cmd == CMD_DELETE_LAST) && (n_status == ST_OK);
            end
            if (resolve) begin
                r_busy       <= 1'b0;
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_found  <= (r_is_search && any_match) ? INDEX_W'(first_index)
                                                           : NONE_INDEX;
                r_out_data   <= r_is_delete ? IO_DATA_W'(tail_value) : '0;
                r_out_count  <= COUNT_W'(r_fill);
                r_out_empty  <= (r_fill == '0);
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_found;
    assign o_data_out    = r_out_data;
    assign o_count       = r_out_count;
    assign o_empty_res   = r_out_empty;

endmodule

// File: test/sequential_list_engine_test.sv
`timescale 1ns / 1ps

module sequential_list_engine_test
    import sle_pkg::*;
();

    localparam int LIST_CAPACITY = 64;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [INDEX_W-1:0]   index;
        logic [IO_DATA_W-1:0] removed;
        logic [COUNT_W-1:0]   entries;
        logic                 empty;
    } t_list_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [CMD_W-1:0]     i_cmd        = '0;
    logic [POS_W-1:0]     i_position   = '0;
    logic [IO_DATA_W-1:0] i_data_in    = '0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [INDEX_W-1:0]   o_found_index;
    logic [IO_DATA_W-1:0] o_data_out;
    logic [COUNT_W-1:0]   o_count;
    logic                 o_empty_res;

    logic [IO_DATA_W-1:0] list_cells [LIST_CAPACITY];
    int                   list_fill = 0;
    t_list_result         expected_results [$];

    bit source_gaps     = 1'b1;
    bit sink_stalls     = 1'b1;
    int hold_off_cycles = 0;

    int cycles_elapsed  = 0;
    int mismatch_count  = 0;
    int commands_sent   = 0;
    int results_checked = 0;
    int overflow_count  = 0;
    int error_count     = 0;
    int search_hits     = 0;
    int peak_fill       = 0;

    sequential_list_engine #(
        .CAPACITY  (LIST_CAPACITY),
        .DATA_WIDTH(IO_DATA_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_data_in    (i_data_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_data_out   (o_data_out),
        .o_count      (o_count),
        .o_empty_res  (o_empty_res)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles_elapsed++;
        if (cycles_elapsed >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles_elapsed, expected_results.size());
            $display("sequential_list_engine_test failed");
            $finish;
        end
    end

    // Applies one command to the list copy and returns the result it must produce.
    function automatic t_list_result apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [IO_DATA_W-1:0] value);
        t_list_result res;
        int           slot;
        int           p;
        p           = pos;
        res.status  = ST_OK;
        res.index   = NONE_INDEX;
        res.removed = '0;
        case (cmd)
            CMD_INSERT: begin
                if (p < 1 || p > list_fill + 1) begin
                    res.status = ST_ERROR;
                end else if (list_fill >= LIST_CAPACITY) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    for (slot = list_fill; slot >= p; slot--)
                        list_cells[slot] = list_cells[slot - 1];
                    list_cells[p - 1] = value;
                    list_fill++;
                end
            end
            CMD_APPEND: begin
                if (list_fill >= LIST_CAPACITY) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    list_cells[list_fill] = value;
                    list_fill++;
                end
            end
            CMD_DELETE_LAST: begin
                if (list_fill == 0) begin
                    res.status = ST_ERROR;
                end else begin
                    list_fill--;
                    res.removed = list_cells[list_fill];
                end
            end
            CMD_SEARCH: begin
                for (slot = 0; slot < list_fill; slot++) begin
                    if (res.index == NONE_INDEX && list_cells[slot] == value)
                        res.index = slot[INDEX_W-1:0];
                end
            end
            CMD_CLEAR: begin
                list_fill = 0;
            end
            default: begin
                res.status = ST_ERROR;
            end
        endcase
        res.entries = list_fill[COUNT_W-1:0];
        res.empty   = (list_fill == 0);
        return res;
    endfunction

    function automatic int stall_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [POS_W-1:0] random_pos();
        return POS_W'($urandom_range(0, 127));
    endfunction

    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic [IO_DATA_W-1:0] value);
        t_list_result res;
        int           gap;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_data_in  <= value;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        res = apply_command(cmd, pos, value);
        expected_results.push_back(res);
        commands_sent++;
        if (res.status == ST_OVERFLOW)
            overflow_count++;
        if (res.status == ST_ERROR)
            error_count++;
        if (cmd == CMD_SEARCH && res.index != NONE_INDEX)
            search_hits++;
        if (list_fill > peak_fill)
            peak_fill = list_fill;
        if (source_gaps && $urandom_range(0, 99) < 30) begin
            gap = stall_length();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_command(input int grow_pct);
        logic [CMD_W-1:0]     cmd;
        logic [POS_W-1:0]     pos;
        logic [IO_DATA_W-1:0] value;
        int                   roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            cmd = CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
        else if (roll < 4)
            cmd = CMD_CLEAR;
        else if (roll < 24)
            cmd = CMD_SEARCH;
        else if ($urandom_range(0, 99) < grow_pct)
            cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
        else
            cmd = CMD_DELETE_LAST;

        roll = $urandom_range(0, 9);
        if (roll == 0)
            pos = '0;
        else if (roll == 1)
            pos = random_pos();
        else
            pos = POS_W'($urandom_range(1, list_fill + 1));

        roll = $urandom_range(0, 9);
        if (cmd == CMD_SEARCH && list_fill > 0 && roll < 6)
            value = list_cells[$urandom_range(0, list_fill - 1)];
        else if (roll == 0)
            value = '0;
        else if (roll == 1)
            value = '1;
        else if (roll < 4)
            value = IO_DATA_W'($urandom_range(0, 7));
        else
            value = $urandom;
        send_command(cmd, pos, value);
    endtask

    task automatic report_failure(input t_list_result want, input bit orphan);
        if (mismatch_count < REPORT_LIMIT) begin
            if (orphan)
                $display("Result %0d arrived with nothing expected.", results_checked);
            else
                $display("Result %0d expected status %0d index %0d data %h count %0d empty %0b",
                         results_checked, want.status, $signed(want.index), want.removed,
                         want.entries, want.empty);
            $display("    got status %0d index %0d data %h count %0d empty %0b",
                     o_status, $signed(o_found_index), o_data_out, o_count, o_empty_res);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                want = '0;
                report_failure(want, 1'b1);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_found_index !== want.index ||
                    o_data_out !== want.removed || o_count !== want.entries ||
                    o_empty_res !== want.empty)
                    report_failure(want, 1'b0);
            end
            results_checked++;
        end
    end

    initial begin : result_sink
        int pause;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
                i_out_ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
                pause = stall_length();
                i_out_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_empty_and_edges();
        int code;
        send_command(CMD_DELETE_LAST, random_pos(), $urandom);
        send_command(CMD_SEARCH, '0, '0);
        send_command(CMD_INSERT, 7'd0, 32'h0000_0001);
        send_command(CMD_INSERT, 7'd2, 32'h0000_0002);
        send_command(CMD_INSERT, 7'd1, '0);
        send_command(CMD_APPEND, '1, '1);
        send_command(CMD_INSERT, 7'd1, 32'h8000_0001);
        send_command(CMD_INSERT, 7'd3, 32'h0000_0001);
        send_command(CMD_INSERT, 7'd5, 32'h5555_AAAA);
        send_command(CMD_INSERT, 7'd7, 32'h0000_0003);
        send_command(CMD_INSERT, 7'd127, 32'h0000_0004);
        send_command(CMD_APPEND, '0, '0);
        send_command(CMD_SEARCH, '0, '0);
        send_command(CMD_SEARCH, '1, '1);
        send_command(CMD_SEARCH, 7'd9, 32'h1234_5678);
        for (code = CMD_RESERVED_FIRST; code <= CMD_RESERVED_LAST; code++)
            send_command(code[CMD_W-1:0], random_pos(), $urandom);
        send_command(CMD_DELETE_LAST, '0, '0);
        send_command(CMD_DELETE_LAST, '0, '0);
        send_command(CMD_CLEAR, random_pos(), $urandom);
        send_command(CMD_SEARCH, '0, 32'h8000_0001);
        send_command(CMD_CLEAR, '0, '0);
        send_command(CMD_APPEND, '0, 32'hAAAA_5555);
    endtask

    task automatic test_full_list();
        send_command(CMD_CLEAR, '0, '0);
        while (list_fill < LIST_CAPACITY)
            send_command(CMD_APPEND, random_pos(), $urandom);
        send_command(CMD_INSERT, 7'd1, $urandom);
        send_command(CMD_INSERT, POS_W'(LIST_CAPACITY + 1), $urandom);
        send_command(CMD_INSERT, POS_W'(LIST_CAPACITY + 2), $urandom);
        send_command(CMD_APPEND, '0, $urandom);
        send_command(CMD_SEARCH, '0, list_cells[LIST_CAPACITY - 1]);
        send_command(CMD_DELETE_LAST, '0, '0);
        send_command(CMD_INSERT, POS_W'(LIST_CAPACITY), 32'hDEAD_BEEF);
        send_command(CMD_SEARCH, '0, 32'hDEAD_BEEF);
        send_command(CMD_DELETE_LAST, '0, '0);
        send_command(CMD_CLEAR, '0, '0);
    endtask

    task automatic test_random_mix(input int item_total);
        int k;
        int grow_pct;
        grow_pct = 50;
        for (k = 0; k < item_total; k++) begin
            if (k % 100 == 0) begin
                grow_pct    = $urandom_range(10, 95);
                source_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            send_random_command(grow_pct);
        end
    endtask

    task automatic test_output_backpressure();
        int k;
        source_gaps     = 1'b0;
        sink_stalls     = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        for (k = 0; k < 40; k++)
            send_random_command(80);
        sink_stalls = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_edges();
        test_full_list();
        test_random_mix(1050);
        test_output_backpressure();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Ran %0d commands and checked %0d results, %0d of them wrong.",
                 commands_sent, results_checked, mismatch_count);
        $display("Saw %0d overflows, %0d errors and %0d search hits; list peaked at %0d.",
                 overflow_count, error_count, search_hits, peak_fill);
        if (mismatch_count == 0)
            $display("sequential_list_engine_test passed");
        else
            $display("sequential_list_engine_test failed");
        $finish;
    end

endmodule
